### design/lci_pkg.sv
// Shared types and constants for the level crossing interpolator.
package lci_pkg;

  localparam int COORD_W   = 32;
  localparam int ID_W      = 8;
  localparam int IDX_W     = 16;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [0:0] REG_LEVEL  = 1'b0;
  localparam logic [0:0] REG_INTERP = 1'b1;

  typedef struct packed {
    logic accept;
    logic eval;
    logic mul;
    logic div_step;
    logic load_out;
  } lci_cmd_t;

  typedef struct packed {
    logic hit;
    logic need_div;
  } lci_status_t;

endpackage

### design/lci_ctrl.sv
// Controller state machine for the level crossing interpolator.
module lci_ctrl
  import lci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  lci_status_t status,
  output lci_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_WRITE
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] step;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.eval     = (state == S_EVAL);
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.load_out = (state == S_WRITE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      priority if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (!status.hit) begin
            state <= S_IDLE;
          end else if (status.need_div) begin
            state <= S_MUL;
          end else begin
            state <= S_WRITE;
          end
        end
        S_MUL: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/lci_dp.sv
// Datapath: sample history, bracket test, multiplier and restoring divider.
module lci_dp
  import lci_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lci_cmd_t                  cmd,
  output lci_status_t               status,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      curve_start,
  input  logic [ID_W-1:0]           curve_id,
  input  logic signed [COORD_W-1:0] sample_x,
  input  logic signed [COORD_W-1:0] sample_y,
  output logic [ID_W-1:0]           hit_curve,
  output logic [IDX_W-1:0]          segment_index,
  output logic signed [COORD_W-1:0] crossing_x,
  output logic signed [COORD_W-1:0] crossing_y
);

  logic signed [COORD_W-1:0] level;
  logic                      interp;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic                      prev_valid;
  logic [COUNT_WIDTH-1:0]    count;
  logic [COUNT_WIDTH-1:0]    count_eff;
  logic [IDX_W-1:0]          idx_now;

  logic signed [COORD_W-1:0] x1, y1, x2, y2;
  logic [ID_W-1:0]           id;
  logic [IDX_W-1:0]          idx;
  logic                      pair_ok;

  logic signed [COORD_W:0]   num, dx, dy, d1, d2;
  logic [COORD_W:0]          num_mag, dx_mag, dy_mag, d1_mag, d2_mag;

  logic [COORD_W-1:0]        mn, mdx, md;
  logic                      neg;
  logic                      pick_first;
  logic                      use_interp;
  logic [2*COORD_W-1:0]      prod;
  logic [COORD_W-1:0]        rem;
  logic [COORD_W-1:0]        dvd;
  logic [COORD_W:0]          trial;
  logic [COORD_W:0]          trial_diff;

  // Segment test on the held pair
  assign num = COORD_W'(0) + ({level[COORD_W-1], level} - {y1[COORD_W-1], y1});
  assign dx  = {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
  assign dy  = {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
  assign d1  = {y1[COORD_W-1], y1} - {level[COORD_W-1], level};
  assign d2  = {y2[COORD_W-1], y2} - {level[COORD_W-1], level};

  assign num_mag = num[COORD_W] ? -num : num;
  assign dx_mag  = dx[COORD_W]  ? -dx  : dx;
  assign dy_mag  = dy[COORD_W]  ? -dy  : dy;
  assign d1_mag  = d1[COORD_W]  ? -d1  : d1;
  assign d2_mag  = d2[COORD_W]  ? -d2  : d2;

  assign status.hit = pair_ok &&
                      (((y1 <= level) && (level <= y2)) || ((y2 <= level) && (level <= y1)));
  assign status.need_div = interp && (y1 != y2);

  // Index of the incoming sample within its curve
  assign count_eff = curve_start ? '0 : count;

  if (COUNT_WIDTH > IDX_W) begin : g_clamp
    assign idx_now = (|count_eff[COUNT_WIDTH-1:IDX_W]) ? '1 : count_eff[IDX_W-1:0];
  end else begin : g_extend
    assign idx_now = IDX_W'(count_eff);
  end

  assign prod       = mn * mdx;
  assign trial      = {rem, dvd[COORD_W-1]};
  assign trial_diff = trial - {1'b0, md};

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= '0;
      interp     <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEVEL:  level  <= cfg_data;
          REG_INTERP: interp <= cfg_data[0];
          default:    ;
        endcase
      end
      if (cmd.accept) begin
        prev_x     <= sample_x;
        prev_y     <= sample_y;
        prev_valid <= 1'b1;
        count      <= (&count_eff) ? count_eff : count_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x1      <= prev_x;
      y1      <= prev_y;
      x2      <= sample_x;
      y2      <= sample_y;
      id      <= curve_id;
      idx     <= idx_now;
      pair_ok <= prev_valid && !curve_start;
    end
    if (cmd.eval) begin
      mn         <= num_mag[COORD_W-1:0];
      mdx        <= dx_mag[COORD_W-1:0];
      md         <= dy_mag[COORD_W-1:0];
      neg        <= num[COORD_W] ^ dx[COORD_W] ^ dy[COORD_W];
      pick_first <= d1_mag < d2_mag;
      use_interp <= status.need_div;
    end
    if (cmd.mul) begin
      rem <= prod[2*COORD_W-1:COORD_W];
      dvd <= prod[COORD_W-1:0];
    end
    if (cmd.div_step) begin
      if (!trial_diff[COORD_W]) begin
        rem <= trial_diff[COORD_W-1:0];
        dvd <= {dvd[COORD_W-2:0], 1'b1};
      end else begin
        rem <= trial[COORD_W-1:0];
        dvd <= {dvd[COORD_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      hit_curve     <= id;
      segment_index <= idx;
      priority if (use_interp) begin
        crossing_x <= neg ? x1 - dvd : x1 + dvd;
        crossing_y <= level;
      end else if (pick_first) begin
        crossing_x <= x1;
        crossing_y <= y1;
      end else begin
        crossing_x <= x2;
        crossing_y <= y2;
      end
    end
  end

endmodule

### design/level_crossing_interpolator.sv
// Top level of the level crossing interpolator.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   curve_start, curve_id, sample_x, sample_y
//  out      source     out_valid/out_stall hit_curve, segment_index, crossing_x, crossing_y
//  cfg      sink       cfg_we              cfg_index, cfg_data
//
//  A sample with no crossing ends after evaluation; a nearest-sample crossing is then
//  written; an interpolated one first runs the multiply and 32-step restoring divider.
//  One sample is worked at a time; the output register frees the input side.
//  A stalled result holds the block in its write step until the transfer.
//  rst is synchronous and clears history, count and configuration.
module level_crossing_interpolator
  import lci_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      curve_start,
  input  logic [ID_W-1:0]           curve_id,
  input  logic signed [COORD_W-1:0] sample_x,
  input  logic signed [COORD_W-1:0] sample_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ID_W-1:0]           hit_curve,
  output logic [IDX_W-1:0]          segment_index,
  output logic signed [COORD_W-1:0] crossing_x,
  output logic signed [COORD_W-1:0] crossing_y,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_data
);

  lci_cmd_t    cmd;
  lci_status_t status;

  lci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lci_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .curve_start   (curve_start),
    .curve_id      (curve_id),
    .sample_x      (sample_x),
    .sample_y      (sample_y),
    .hit_curve     (hit_curve),
    .segment_index (segment_index),
    .crossing_x    (crossing_x),
    .crossing_y    (crossing_y)
  );

endmodule
